// File: hdl/rat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_pkg: shared types and constants for the rational accumulator ALU
// Action and status codes, word sizes and the divider request/response structs.
// ----------------------------------------------------------------------------
package rat_pkg;

  localparam int WORD_BITS = 32;
  localparam int DIV_BITS  = 2 * WORD_BITS;
  localparam int CNT_BITS  = $clog2(DIV_BITS);

  // magnitude limit 2^(WORD_BITS-1)
  localparam logic [DIV_BITS-1:0] LIM = DIV_BITS'(1) << (WORD_BITS - 1);

  typedef enum logic [2:0] {
    ACT_LOAD = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_ZERO = 2'd1,
    STS_OVF  = 2'd2
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SETUP,
    S_GCD,
    S_GCDW,
    S_DIVM,
    S_DIVQS,
    S_DIVQ,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
    logic [DIV_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

// File: hdl/rat_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the results.
// ----------------------------------------------------------------------------
module rat_div import rat_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0] qr;
  logic [DIV_BITS-1:0] rr;
  logic [DIV_BITS-1:0] dr;
  logic [DIV_BITS:0]   rr_sh;
  logic [DIV_BITS:0]   diff;
  logic                ge;

  // one trial subtraction per cycle
  always_comb begin
    rr_sh = {rr, qr[DIV_BITS-1]};
    diff  = rr_sh - {1'b0, dr};
    ge    = !diff[DIV_BITS];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      qr <= req.dividend;
      rr <= '0;
      dr <= req.divisor;
    end else if (busy) begin
      rr <= ge ? diff[DIV_BITS-1:0] : rr_sh[DIV_BITS-1:0];
      qr <= {qr[DIV_BITS-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = qr;
  assign rsp.remainder = rr;

endmodule

// File: hdl/rational_accumulator_alu_unit.sv
`timescale 1ns / 1ps
// Sequence: products (not for load), setup, Euclid steps on the divider, two divisions for the
// reduction, check and output; codes that fail early go straight to output.
// One transaction at a time: s_tready is high only while idle, and all steps share the 64-bit bit-serial divider.
// Reset (rst, synchronous, active high) sets the accumulator to 0/1 and empties
// the output register.
// ----------------------------------------------------------------------------
// rational_accumulator_alu_unit: rational accumulator with gcd reduction
// Shared multiplier and iterative divider under one sequencer.
// ----------------------------------------------------------------------------
module rational_accumulator_alu_unit import rat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[2:0], operand_numerator[34:3], operand_denominator[66:35], zero fill
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_numerator[31:0], result_denominator[62:32], status[64:63], zero fill
  output logic [71:0] m_tdata
);

  state_t state, state_next;

  logic [2:0]            action;
  logic                  on_neg;
  logic [WORD_BITS-1:0]  on_mag;
  logic [WORD_BITS-1:0]  od_mag;
  logic                  a_neg;
  logic [WORD_BITS-1:0]  a_mag;
  logic [1:0]            mul_cnt;
  logic [DIV_BITS-1:0]   p1, p2, p3;
  logic                  num_neg;
  logic [DIV_BITS-1:0]   nm, dn, gx, gy, m_val;
  sts_t                  sts;
  logic [WORD_BITS-1:0]  acc_num;
  logic [WORD_BITS-2:0]  acc_den;
  logic [71:0]           out_data;

  logic [2:0]            in_act;
  logic [WORD_BITS-1:0]  in_num, in_den, in_on_mag, in_od_mag;
  logic                  in_on_neg;
  logic [WORD_BITS-1:0]  mop_a, mop_b;
  logic [DIV_BITS-1:0]   mprod;
  logic                  addsub;
  logic                  t2_neg, c_neg;
  logic [DIV_BITS-1:0]   c_mag;
  logic                  r_neg, ovf;
  div_req_t              dreq;
  div_rsp_t              drsp;
  logic                  out_load;

  rat_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // input unpack and sign folding
  always_comb begin
    in_act    = s_tdata[2:0];
    in_num    = s_tdata[34:3];
    in_den    = s_tdata[66:35];
    in_on_mag = in_num[WORD_BITS-1] ? (~in_num + 1'b1) : in_num;
    in_od_mag = in_den[WORD_BITS-1] ? (~in_den + 1'b1) : in_den;
    in_on_neg = in_num[WORD_BITS-1] ^ (in_den[WORD_BITS-1] && (in_on_mag != '0));
  end

  assign addsub   = (action == ACT_ADD) || (action == ACT_SUB);
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_EMIT) && (!m_tvalid || m_tready);

  // shared multiplier operand select
  always_comb begin
    case (mul_cnt)
      2'd0: begin
        mop_a = a_mag;
        mop_b = (action == ACT_MUL) ? on_mag : od_mag;
      end
      2'd1: begin
        mop_a = {1'b0, acc_den};
        mop_b = (action == ACT_DIV) ? on_mag : od_mag;
      end
      default: begin
        mop_a = on_mag;
        mop_b = {1'b0, acc_den};
      end
    endcase
    mprod = mop_a * mop_b;
  end

  // signed sum of the two cross products
  always_comb begin
    t2_neg = (action == ACT_SUB) ? !on_neg : on_neg;
    if (p2 == '0) t2_neg = 1'b0;
    if (a_neg == t2_neg) begin
      c_neg = a_neg;
      c_mag = p1 + p2;
    end else if (p1 >= p2) begin
      c_neg = a_neg;
      c_mag = p1 - p2;
    end else begin
      c_neg = t2_neg;
      c_mag = p2 - p1;
    end
  end

  // fit check on the reduced result
  always_comb begin
    r_neg = num_neg && (m_val != '0);
    ovf   = (drsp.quotient >= LIM) || (r_neg ? (m_val > LIM) : (m_val >= LIM));
  end

  // divider requests
  always_comb begin
    dreq = '0;
    if (state == S_GCD) begin
      dreq.start    = 1'b1;
      dreq.dividend = (gy == '0) ? nm : gx;
      dreq.divisor  = (gy == '0) ? gx : gy;
    end else if (state == S_DIVQS) begin
      dreq.start    = 1'b1;
      dreq.dividend = dn;
      dreq.divisor  = gx;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_act > ACT_DIV || in_od_mag == '0 ||
              (in_act == ACT_DIV && in_on_mag == '0)) state_next = S_EMIT;
          else if (in_act == ACT_LOAD)              state_next = S_SETUP;
          else                                      state_next = S_MUL;
        end
      end
      S_MUL:   if (mul_cnt == 2'd2 || (mul_cnt == 2'd1 && !addsub)) state_next = S_SETUP;
      S_SETUP: state_next = S_GCD;
      S_GCD:   state_next = (gy == '0) ? S_DIVM : S_GCDW;
      S_GCDW:  if (drsp.done) state_next = S_GCD;
      S_DIVM:  if (drsp.done) state_next = S_DIVQS;
      S_DIVQS: state_next = S_DIVQ;
      S_DIVQ:  if (drsp.done) state_next = S_CHECK;
      S_CHECK: state_next = S_EMIT;
      S_EMIT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num  <= '0;
      acc_den  <= (WORD_BITS-1)'(1);
      m_tvalid <= 1'b0;
      mul_cnt  <= '0;
      sts      <= STS_OK;
    end else begin
      if (out_load)                   m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)  m_tvalid <= 1'b0;
      if (state == S_IDLE) begin
        mul_cnt <= '0;
        if (in_od_mag == '0 && in_act <= ACT_DIV)       sts <= STS_ZERO;
        else if (in_act == ACT_DIV && in_on_mag == '0)  sts <= STS_ZERO;
        else                                            sts <= STS_OK;
      end
      if (state == S_MUL) mul_cnt <= mul_cnt + 1'b1;
      if (state == S_CHECK) begin
        if (ovf) begin
          sts <= STS_OVF;
        end else begin
          acc_num <= r_neg ? (~m_val[WORD_BITS-1:0] + 1'b1) : m_val[WORD_BITS-1:0];
          acc_den <= drsp.quotient[WORD_BITS-2:0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      action <= in_act;
      on_neg <= in_on_neg;
      on_mag <= in_on_mag;
      od_mag <= in_od_mag;
      a_neg  <= acc_num[WORD_BITS-1];
      a_mag  <= acc_num[WORD_BITS-1] ? (~acc_num + 1'b1) : acc_num;
    end
    if (state == S_MUL) begin
      case (mul_cnt)
        2'd0:    p1 <= mprod;
        2'd1:    p3 <= mprod;
        default: p2 <= mprod;
      endcase
    end
    if (state == S_SETUP) begin
      case (action)
        ACT_LOAD: begin
          num_neg <= on_neg;
          nm      <= DIV_BITS'(on_mag);
          gx      <= DIV_BITS'(on_mag);
          dn      <= DIV_BITS'(od_mag);
          gy      <= DIV_BITS'(od_mag);
        end
        ACT_ADD, ACT_SUB: begin
          num_neg <= c_neg;
          nm      <= c_mag;
          gx      <= c_mag;
          dn      <= p3;
          gy      <= p3;
        end
        default: begin
          num_neg <= a_neg ^ on_neg;
          nm      <= p1;
          gx      <= p1;
          dn      <= p3;
          gy      <= p3;
        end
      endcase
    end
    if (state == S_GCDW && drsp.done) begin
      gx <= gy;
      gy <= drsp.remainder;
    end
    if (state == S_DIVM && drsp.done) m_val <= drsp.quotient;
    if (out_load) out_data <= {7'd0, sts, acc_den, acc_num};
  end

  assign m_tdata = out_data;

`ifndef SYNTH
  // an accepted transaction always leaves idle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accept");

  // the accumulator denominator is never zero
  assert property (@(posedge clk) disable iff (rst) (acc_den != '0))
    else $error("accumulator denominator is zero");

  // a failing transaction does not touch the accumulator
  assert property (@(posedge clk) disable iff (rst)
    (out_load && sts != STS_OK) |=> ($stable(acc_num) && $stable(acc_den)))
    else $error("accumulator changed on error status");

  // the divider never reports done while the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !drsp.done)
    else $error("divider done while idle");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the rational accumulator ALU
// A local rational predictor follows every accepted transaction and each
// output transaction is checked field by field against the oldest expectation.
// Directed corner cases, a backpressure phase and random traffic with gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import rat_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;

  // packed from the top bit down, so the numerator lands in the low bits
  typedef struct packed {
    logic [1:0]  sts;
    logic [30:0] den;
    logic [31:0] num;
  } acc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  acc_result_t result_q[$];
  logic [31:0] model_num = 32'd0;
  logic [31:0] model_den = 32'd1;
  int          errors = 0;
  int          cycles = 0;
  bit          sink_hold = 1'b0;
  bit          sink_busy = 1'b0;

  rational_accumulator_alu_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("rational_accumulator_alu_unit: mismatch");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // sink ready with random stalls, held high while sink_busy, or held low during the pressure phase
  always @(posedge clk) begin
    if (sink_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0) || sink_busy;
    end
  end

  function automatic logic [63:0] mag32(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduce neg/mag over den, commit to the accumulator when it fits
  function automatic logic [1:0] reduce_fit(bit neg, logic [63:0] mag, logic [63:0] den);
    logic [63:0] g, m, q;
    g = euclid(mag, den);
    m = mag / g;
    q = den / g;
    neg = neg && (m != 0);
    if (q >= LIM) return STS_OVF;
    if (neg ? (m > LIM) : (m >= LIM)) return STS_OVF;
    model_num = neg ? (32'd0 - m[31:0]) : m[31:0];
    model_den = q[31:0];
    return STS_OK;
  endfunction

  function automatic acc_result_t predict_rational(logic [2:0] act, logic [31:0] onum,
                                                   logic [31:0] oden);
    acc_result_t res;
    bit          on_neg, a_neg, t1_neg, t2_neg, s_neg;
    logic [63:0] on_mag, od_mag, a_mag, b, t1, t2, s_mag;
    logic [1:0]  sts;
    on_neg = onum[31];
    on_mag = mag32(onum);
    od_mag = mag32(oden);
    a_neg  = model_num[31];
    a_mag  = mag32(model_num);
    b      = {32'd0, model_den};
    sts    = STS_OK;
    // move the denominator sign onto the numerator
    if (oden[31] && on_mag != 0) on_neg = !on_neg;
    if (act <= ACT_DIV) begin
      if (od_mag == 0) begin
        sts = STS_ZERO;
      end else if (act == ACT_LOAD) begin
        sts = reduce_fit(on_neg, on_mag, od_mag);
      end else if (act == ACT_ADD || act == ACT_SUB) begin
        t1_neg = a_neg;
        t1 = a_mag * od_mag;
        t2_neg = (act == ACT_SUB) ? !on_neg : on_neg;
        t2 = on_mag * b;
        if (t2 == 0) t2_neg = 1'b0;
        if (t1_neg == t2_neg) begin
          s_neg = t1_neg;
          s_mag = t1 + t2;
        end else if (t1 >= t2) begin
          s_neg = t1_neg;
          s_mag = t1 - t2;
        end else begin
          s_neg = t2_neg;
          s_mag = t2 - t1;
        end
        sts = reduce_fit(s_neg && s_mag != 0, s_mag, b * od_mag);
      end else if (act == ACT_MUL) begin
        sts = reduce_fit(a_neg != on_neg, a_mag * on_mag, b * od_mag);
      end else begin
        if (on_mag == 0) sts = STS_ZERO;
        else sts = reduce_fit(a_neg != on_neg, a_mag * od_mag, b * on_mag);
      end
    end
    res.num = model_num;
    res.den = model_den[30:0];
    res.sts = sts;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    errors++;
  endtask

  // check each output transaction against the oldest expectation
  always @(posedge clk) begin
    acc_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[64:0];
      if (result_q.size() == 0) begin
        report_mismatch("unexpected transaction", got.num, 32'd0);
      end else begin
        want = result_q.pop_front();
        if (got.num !== want.num) report_mismatch("numerator", got.num, want.num);
        if (got.den !== want.den)
          report_mismatch("denominator", 32'(got.den), 32'(want.den));
        if (got.sts !== want.sts)
          report_mismatch("status", 32'(got.sts), 32'(want.sts));
      end
    end
  end

  // offer one transaction after an optional gap, predict on acceptance
  task automatic send_op(logic [2:0] act, logic [31:0] onum, logic [31:0] oden, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, oden, onum, act};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    result_q.push_back(predict_rational(act, onum, oden));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 40) - 20;
    if (r < 7) return $urandom_range(0, 200000) - 100000;
    if (r < 8) return (r % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic test_directed();
    send_op(ACT_LOAD, 3, 4, 0);
    send_op(ACT_ADD, 1, 6, 0);
    send_op(ACT_SUB, 5, 12, 1);
    send_op(ACT_MUL, -6, 7, 0);
    send_op(ACT_DIV, 3, -5, 2);
    send_op(ACT_LOAD, 9, 0, 0);
    send_op(ACT_DIV, 0, 4, 0);
    send_op(ACT_MUL, 0, 9, 0);
    send_op(ACT_LOAD, -7, -14, 0);
    send_op(ACT_ADD, 2, 1, 0);
    send_op(3'd5, 1, 1, 0);
    send_op(3'd6, 0, 0, 0);
    send_op(3'd7, 32'hffff_ffff, 32'h8000_0000, 0);
    send_op(ACT_LOAD, 32'h8000_0000, 1, 0);
    send_op(ACT_LOAD, 32'h8000_0000, 32'hffff_ffff, 0);
    send_op(ACT_LOAD, 1, 32'h8000_0000, 0);
    send_op(ACT_LOAD, 32'h7fff_ffff, 32'h7fff_fffe, 0);
    send_op(ACT_ADD, 32'h7fff_ffff, 1, 0);
    send_op(ACT_MUL, 32'h7fff_ffff, 3, 0);
    send_op(ACT_LOAD, 0, 5, 0);
    send_op(ACT_SUB, 32'h8000_0000, 32'hffff_ffff, 0);
    send_op(ACT_DIV, 32'h8000_0000, 32'h7fff_ffff, 0);
    drain();
  endtask

  // sink stalls for a long stretch while the source keeps offering
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (3000) @(posedge clk);
        sink_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) send_op(ACT_ADD, $urandom_range(1, 9), 1, 0);
    drain();
  endtask

  task automatic test_random();
    logic [2:0]  act;
    logic [31:0] onum, oden;
    for (int i = 0; i < 400; i++) begin
      act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      onum = rand_word();
      oden = ($urandom_range(0, 3) == 0) ? 32'd1 : rand_word();
      if (i % 100 == 50) sink_busy = 1'b1;
      if (i % 100 == 80) sink_busy = 1'b0;
      send_op(act, onum, oden, (i % 100 > 50 && i % 100 < 80) ? 0 : rand_gap());
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("rational_accumulator_alu_unit: match");
    end else begin
      $display("rational_accumulator_alu_unit: mismatch");
    end
    $finish;
  end

endmodule
